[src/yags_pkg.sv]
// Shared types, constants and the counter step for the YAGS branch predictor.
// No dependencies; used by the yags_branch_predictor top level.
package yags_pkg;

    // address and stream payload widths; the tdata widths are whole bytes
    localparam int ADDR_W    = 32;
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 8;

    // saturating direction counters
    localparam int CTR_W = 2;

    typedef logic [CTR_W-1:0] ctr_t;

    localparam ctr_t CTR_MAX = '1;

    typedef enum logic {
        ACT_LOOKUP = 1'b0,
        ACT_UPDATE = 1'b1
    } action_t;

    // step a counter toward the resolved direction, saturating at both ends
    function automatic ctr_t ctr_step(ctr_t c, logic up);
        ctr_t r;
        r = c;
        if (up) begin
            if (c != CTR_MAX) r = c + ctr_t'(1);
        end else begin
            if (c != '0) r = c - ctr_t'(1);
        end
        return r;
    endfunction

endpackage

[src/yags_branch_predictor.sv]
// YAGS branch predictor top level: choice table, two 2-way exception caches,
// global history, result register. Depends on yags_pkg.
//
// Each input transaction is a lookup or an update for one branch address and
// yields exactly one result transaction: the prediction, whether the selected
// exception cache hit, and the choice counter's upper bit. The block takes one
// transaction per cycle while the result side is not stalled. Acceptance reads
// the choice table and both cache rows into registers; when the second stage
// advances it forms the prediction, writes the trained rows back and loads the
// result register. A one-entry write bypass per memory covers an item that
// reads a row in the same cycle the previous item writes it. Global history is
// shifted when an update is accepted, so a following item indexes with it at
// once. After reset the block sweeps all memories to zero, one row a cycle,
// through 2**max(CHOICE_INDEX_BITS, CACHE_INDEX_BITS) indices (4096 by default);
// s_tready stays low during that sweep. The input side keeps accepting while a
// finished result waits on m_tready, until the second stage is also full.
module yags_branch_predictor #(
    parameter int CHOICE_INDEX_BITS = 12,
    parameter int CACHE_INDEX_BITS  = 10,
    parameter int TAG_BITS          = 6
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] branch_address, [32] outcome, [39:33] zero
    input  logic [yags_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] action
    input  logic [yags_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] prediction, [1] cache_hit, [2] choice_says_taken, [7:3] zero
    output logic [yags_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int CH_W  = CHOICE_INDEX_BITS;
    localparam int CA_W  = CACHE_INDEX_BITS;
    localparam int TG_W  = TAG_BITS + 1;
    localparam int H_W   = CACHE_INDEX_BITS + 1;
    localparam int CLR_W = (CH_W > CA_W) ? CH_W : CA_W;
    localparam int A_W   = yags_pkg::ADDR_W - 2;

    typedef struct packed {
        logic [TG_W-1:0]  tag;
        yags_pkg::ctr_t   cnt;
    } way_t;

    // one cache set: replace bit and both ways, written as a whole row
    typedef struct packed {
        logic repl;
        way_t w1;
        way_t w0;
    } set_t;

    // ---------------------------------------------------------------- input
    logic                  accept;
    logic [A_W-1:0]        in_a;
    logic                  in_outcome;
    yags_pkg::action_t     in_action;
    logic [CH_W-1:0]       in_chi;
    logic [CA_W-1:0]       in_cai;
    logic [TG_W-1:0]       in_tag;

    logic [H_W-1:0]        hist_reg;
    logic                  clearing_reg;
    logic [CLR_W-1:0]      clr_idx_reg;

    // second stage (item whose rows are in the read registers)
    logic                  s1_valid_reg;
    yags_pkg::action_t     s1_action_reg;
    logic                  s1_outcome_reg;
    logic [CH_W-1:0]       s1_chi_reg;
    logic [CA_W-1:0]       s1_cai_reg;
    logic [TG_W-1:0]       s1_tag_reg;
    logic                  s1_adv;

    logic                  m_valid_reg;
    logic [2:0]            m_data_reg;
    logic                  out_free;

    assign in_a       = s_tdata[yags_pkg::ADDR_W-1:2];
    assign in_outcome = s_tdata[yags_pkg::ADDR_W];
    assign in_action  = yags_pkg::action_t'(s_tuser[0]);
    assign in_chi     = in_a[CH_W-1:0];
    assign in_cai     = in_a[CA_W-1:0] ^ hist_reg[H_W-1:1];
    assign in_tag     = {in_a[TAG_BITS-1:0], hist_reg[0]};

    assign out_free = !m_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign accept   = s_tvalid && s_tready;

    // -------------------------------------------------------------- memories
    yags_pkg::ctr_t ch_mem [2**CH_W];
    set_t           t_mem  [2**CA_W];
    set_t           nt_mem [2**CA_W];

    yags_pkg::ctr_t ch_rd_reg;
    set_t           t_rd_reg;
    set_t           nt_rd_reg;

    logic              ch_we;
    logic [CH_W-1:0]   ch_wa;
    yags_pkg::ctr_t    ch_wd;
    logic              t_we;
    logic              nt_we;
    logic [CA_W-1:0]   ca_wa;
    set_t              ca_wd;

    always_ff @(posedge aclk) begin
        if (accept) ch_rd_reg <= ch_mem[in_chi];
        if (ch_we) ch_mem[ch_wa] <= ch_wd;
    end

    always_ff @(posedge aclk) begin
        if (accept) t_rd_reg <= t_mem[in_cai];
        if (t_we) t_mem[ca_wa] <= ca_wd;
    end

    always_ff @(posedge aclk) begin
        if (accept) nt_rd_reg <= nt_mem[in_cai];
        if (nt_we) nt_mem[ca_wa] <= ca_wd;
    end

    // -------------------------------------------------- write bypass entries
    // Hold the newest write to each memory; it supersedes a stale read.
    logic              ch_lw_valid_reg;
    logic [CH_W-1:0]   ch_lw_addr_reg;
    yags_pkg::ctr_t    ch_lw_data_reg;
    logic              t_lw_valid_reg;
    logic [CA_W-1:0]   t_lw_addr_reg;
    set_t              t_lw_data_reg;
    logic              nt_lw_valid_reg;
    logic [CA_W-1:0]   nt_lw_addr_reg;
    set_t              nt_lw_data_reg;

    logic              ch_wr;
    logic              cache_wr;
    logic              chpred;
    yags_pkg::ctr_t    ch_new;
    set_t              new_row;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_lw_valid_reg <= 1'b0;
            t_lw_valid_reg  <= 1'b0;
            nt_lw_valid_reg <= 1'b0;
        end else begin
            if (s1_adv && ch_wr) begin
                ch_lw_valid_reg <= 1'b1;
                ch_lw_addr_reg  <= s1_chi_reg;
                ch_lw_data_reg  <= ch_new;
            end
            if (s1_adv && cache_wr && !chpred) begin
                t_lw_valid_reg <= 1'b1;
                t_lw_addr_reg  <= s1_cai_reg;
                t_lw_data_reg  <= new_row;
            end
            if (s1_adv && cache_wr && chpred) begin
                nt_lw_valid_reg <= 1'b1;
                nt_lw_addr_reg  <= s1_cai_reg;
                nt_lw_data_reg  <= new_row;
            end
        end
    end

    // ------------------------------------------------------ predict and train
    yags_pkg::ctr_t cc;
    set_t           t_row;
    set_t           nt_row;
    set_t           sel;
    logic           hit0;
    logic           hit1;
    logic           hit;
    logic           way;
    yags_pkg::ctr_t hit_cnt;
    logic           pred;
    logic           taken;
    logic           is_upd;
    logic           victim;
    way_t           fill;

    assign cc     = (ch_lw_valid_reg && ch_lw_addr_reg == s1_chi_reg) ? ch_lw_data_reg
                                                                       : ch_rd_reg;
    assign t_row  = (t_lw_valid_reg && t_lw_addr_reg == s1_cai_reg) ? t_lw_data_reg
                                                                     : t_rd_reg;
    assign nt_row = (nt_lw_valid_reg && nt_lw_addr_reg == s1_cai_reg) ? nt_lw_data_reg
                                                                       : nt_rd_reg;

    assign chpred  = cc[yags_pkg::CTR_W-1];
    assign sel     = chpred ? nt_row : t_row;
    assign hit0    = (sel.w0.tag == s1_tag_reg);
    assign hit1    = (sel.w1.tag == s1_tag_reg);
    assign hit     = hit0 || hit1;
    assign way     = !hit0;     // way 0 wins when both hold the tag
    assign hit_cnt = hit0 ? sel.w0.cnt : sel.w1.cnt;
    assign pred    = hit ? hit_cnt[yags_pkg::CTR_W-1] : chpred;
    assign taken   = s1_outcome_reg;
    assign is_upd  = (s1_action_reg == yags_pkg::ACT_UPDATE);
    assign ch_new  = yags_pkg::ctr_step(cc, taken);

    always_comb begin
        ch_wr     = 1'b0;
        cache_wr  = 1'b0;
        new_row   = sel;
        victim    = !sel.repl;
        fill.tag  = s1_tag_reg;
        fill.cnt  = {1'b0, taken};
        if (!is_upd) begin
            // a lookup hit points the replace bit at the used way as the next victim
            if (hit) begin
                cache_wr     = 1'b1;
                new_row.repl = !way;
            end
        end else begin
            // skip choice training when the cache covered its wrong guess
            ch_wr = !((chpred != taken) && hit && (pred == taken));
            if (chpred ? (hit || !taken) : (hit || taken)) begin
                cache_wr = 1'b1;
                if (hit) begin
                    if (!way) new_row.w0.cnt = yags_pkg::ctr_step(sel.w0.cnt, taken);
                    else      new_row.w1.cnt = yags_pkg::ctr_step(sel.w1.cnt, taken);
                end else begin
                    // taken cache prefers the way that predicts not taken
                    if (!chpred && (sel.w0.cnt[yags_pkg::CTR_W-1] !=
                                    sel.w1.cnt[yags_pkg::CTR_W-1])) begin
                        victim = sel.w0.cnt[yags_pkg::CTR_W-1];
                    end
                    if (!victim) new_row.w0 = fill;
                    else         new_row.w1 = fill;
                end
            end
        end
    end

    // write ports: the clearing sweep owns them until it ends
    assign ch_we = clearing_reg || (s1_adv && ch_wr);
    assign ch_wa = clearing_reg ? clr_idx_reg[CH_W-1:0] : s1_chi_reg;
    assign ch_wd = clearing_reg ? '0 : ch_new;
    assign t_we  = clearing_reg || (s1_adv && cache_wr && !chpred);
    assign nt_we = clearing_reg || (s1_adv && cache_wr && chpred);
    assign ca_wa = clearing_reg ? clr_idx_reg[CA_W-1:0] : s1_cai_reg;
    assign ca_wd = clearing_reg ? '0 : new_row;

    // ------------------------------------------------------- control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else if (clearing_reg) begin
            clr_idx_reg <= clr_idx_reg + CLR_W'(1);
            if (&clr_idx_reg) clearing_reg <= 1'b0;
        end
    end

    // shift an update's outcome in at acceptance so the next item indexes with it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
        end else if (accept && in_action == yags_pkg::ACT_UPDATE) begin
            hist_reg <= {hist_reg[H_W-2:0], in_outcome};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_action_reg  <= in_action;
            s1_outcome_reg <= in_outcome;
            s1_chi_reg     <= in_chi;
            s1_cai_reg     <= in_cai;
            s1_tag_reg     <= in_tag;
        end
    end

    // result register: load on advance, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) m_data_reg <= {chpred, hit, pred};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(yags_pkg::M_TDATA_W - 3)'(0), m_data_reg};

`ifndef SYNTH
    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s_tready)
        else $error("input accepted during memory clearing sweep");

    a_one_cache_per_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !clearing_reg |-> !(t_we && nt_we))
        else $error("both exception caches written by one item");

    a_lookup_keeps_choice: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_adv && s1_action_reg == yags_pkg::ACT_LOOKUP) |-> !ch_we)
        else $error("lookup wrote the choice table");
`endif

endmodule

[verif/yags_branch_predictor_tb.sv]
// Self-checking testbench for the YAGS branch predictor. A table of directed
// branches, then a random mix, is checked against a predictor kept in step here.
// Depends on yags_pkg and yags_branch_predictor.
`timescale 1ns / 100ps

module yags_branch_predictor_tb;

    localparam int CHOICE_BITS    = 12;
    localparam int SET_BITS       = 10;
    localparam int TAG_W          = 6;
    localparam int RANDOM_BRANCHES = 850;
    localparam int POOL_SIZE      = 12;
    localparam int STALL_CYCLES   = 300;
    localparam int DRAIN_CYCLES   = 10;
    // reset sweep of 4096 rows plus the long receiver stall, with margin
    localparam int WATCHDOG_LIMIT = 20000;

    // packed to match m_tdata[2:0]
    typedef struct packed {
        logic choice_taken;
        logic cache_hit;
        logic prediction;
    } verdict_t;

    typedef struct packed {
        yags_pkg::action_t act;
        logic [31:0]       addr;
        logic              taken;
        logic              pinned;
        verdict_t          want;
    } branch_row_t;

    localparam int ROWS = 23;

    // The first three rows run on freshly cleared tables: all choice counters
    // are zero, so the taken cache is probed, and tag zero matches fresh entries.
    branch_row_t directed_rows [0:ROWS-1] = '{
        {yags_pkg::ACT_LOOKUP, 32'h0000_0000, 1'b1, 1'b1, 3'b010}, // empty tag zero hits
        {yags_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b1, 3'b000}, // top set, tag miss
        {yags_pkg::ACT_LOOKUP, 32'h0000_0004, 1'b0, 1'b1, 3'b000},
        {yags_pkg::ACT_UPDATE, 32'h0000_0100, 1'b1, 1'b0, 3'b000}, // walk the choice up
        {yags_pkg::ACT_UPDATE, 32'h0000_0100, 1'b1, 1'b0, 3'b000},
        {yags_pkg::ACT_UPDATE, 32'h0000_0100, 1'b1, 1'b0, 3'b000},
        {yags_pkg::ACT_UPDATE, 32'h0000_0100, 1'b1, 1'b0, 3'b000}, // saturate at the top
        {yags_pkg::ACT_LOOKUP, 32'h0000_0100, 1'b0, 1'b0, 3'b000},
        {yags_pkg::ACT_UPDATE, 32'h0000_0100, 1'b0, 1'b0, 3'b000}, // not-taken exceptions
        {yags_pkg::ACT_UPDATE, 32'h0000_0100, 1'b0, 1'b0, 3'b000},
        {yags_pkg::ACT_UPDATE, 32'h0000_0100, 1'b0, 1'b0, 3'b000},
        {yags_pkg::ACT_UPDATE, 32'hFFFF_FFFF, 1'b1, 1'b0, 3'b000},
        {yags_pkg::ACT_UPDATE, 32'hFFFF_FFFF, 1'b1, 1'b0, 3'b000},
        {yags_pkg::ACT_UPDATE, 32'hFFFF_FFFC, 1'b0, 1'b0, 3'b000},
        {yags_pkg::ACT_UPDATE, 32'h0000_0000, 1'b0, 1'b0, 3'b000}, // saturate at the bottom
        {yags_pkg::ACT_UPDATE, 32'h0000_0003, 1'b0, 1'b0, 3'b000}, // byte offset ignored
        {yags_pkg::ACT_UPDATE, 32'h8000_0040, 1'b1, 1'b0, 3'b000}, // alternating pattern
        {yags_pkg::ACT_UPDATE, 32'h8000_0040, 1'b0, 1'b0, 3'b000},
        {yags_pkg::ACT_UPDATE, 32'h8000_0040, 1'b1, 1'b0, 3'b000},
        {yags_pkg::ACT_UPDATE, 32'h8000_0040, 1'b0, 1'b0, 3'b000},
        {yags_pkg::ACT_LOOKUP, 32'h8000_0040, 1'b0, 1'b0, 3'b000},
        {yags_pkg::ACT_LOOKUP, 32'hAAAA_AAA8, 1'b1, 1'b0, 3'b000},
        {yags_pkg::ACT_UPDATE, 32'h5555_5554, 1'b1, 1'b0, 3'b000}
    };

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [yags_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [yags_pkg::S_TUSER_W-1:0] s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [yags_pkg::M_TDATA_W-1:0] m_tdata;

    // expectation riding along with a directed transaction
    logic     row_pinned = 1'b0;
    verdict_t row_result = '0;

    // shadow of the predictor state
    logic [1:0]       choice_ctr [0:(1<<CHOICE_BITS)-1];
    logic [TAG_W:0]   tk_tag     [0:(2<<SET_BITS)-1];
    logic [1:0]       tk_cnt     [0:(2<<SET_BITS)-1];
    logic             tk_repl    [0:(1<<SET_BITS)-1];
    logic [TAG_W:0]   nt_tag     [0:(2<<SET_BITS)-1];
    logic [1:0]       nt_cnt     [0:(2<<SET_BITS)-1];
    logic             nt_repl    [0:(1<<SET_BITS)-1];
    logic [SET_BITS:0] ghist;

    verdict_t pending_results [$];
    int       mismatches     = 0;
    int       quiet_cycles   = 0;
    bit       idle_on        = 1'b1;
    bit       stall_pending  = 1'b0;

    yags_branch_predictor #(
        .CHOICE_INDEX_BITS(CHOICE_BITS),
        .CACHE_INDEX_BITS (SET_BITS),
        .TAG_BITS         (TAG_W)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #6 aclk = ~aclk;

    // saturating 2-bit step toward the resolved direction
    function automatic logic [1:0] nudge_ctr(logic [1:0] c, logic up);
        if (up) return (c == 2'd3) ? c : c + 2'd1;
        return (c == 2'd0) ? c : c - 2'd1;
    endfunction

    // Form the prediction for one branch and advance the shadow state.
    function automatic verdict_t predict_branch(yags_pkg::action_t act, logic [31:0] addr,
                                                logic taken);
        logic [29:0]         a;
        logic [SET_BITS-1:0] set;
        logic [TAG_W:0]      tag;
        logic [1:0]          cc, c0, c1;
        logic [TAG_W:0]      t0, t1;
        logic                ch, hit0, hit1, hit, pred, vw;
        verdict_t            v;
        a    = addr[31:2];
        set  = a[SET_BITS-1:0] ^ ghist[SET_BITS:1];
        tag  = {a[TAG_W-1:0], ghist[0]};
        cc   = choice_ctr[a[CHOICE_BITS-1:0]];
        ch   = cc[1];
        // choice says taken: look for a not-taken exception, and vice versa
        t0   = ch ? nt_tag[{set, 1'b0}] : tk_tag[{set, 1'b0}];
        t1   = ch ? nt_tag[{set, 1'b1}] : tk_tag[{set, 1'b1}];
        c0   = ch ? nt_cnt[{set, 1'b0}] : tk_cnt[{set, 1'b0}];
        c1   = ch ? nt_cnt[{set, 1'b1}] : tk_cnt[{set, 1'b1}];
        hit0 = (t0 == tag);
        hit1 = !hit0 && (t1 == tag);
        hit  = hit0 || hit1;
        pred = hit ? (hit0 ? c0[1] : c1[1]) : ch;
        v.prediction   = pred;
        v.cache_hit    = hit;
        v.choice_taken = ch;

        if (act == yags_pkg::ACT_LOOKUP) begin
            // a lookup hit only points the replace bit at the hit way as the next victim
            if (hit) begin
                if (ch) nt_repl[set] = hit0;
                else    tk_repl[set] = hit0;
            end
            return v;
        end

        // leave the choice alone when a correct exception covered its miss
        if (!((ch != taken) && hit && (pred == taken)))
            choice_ctr[a[CHOICE_BITS-1:0]] = nudge_ctr(cc, taken);

        if (ch && (hit || !taken)) begin
            if (hit) begin
                nt_cnt[{set, hit1}] = nudge_ctr(hit0 ? c0 : c1, taken);
            end else begin
                vw = !nt_repl[set];
                nt_tag[{set, vw}] = tag;
                nt_cnt[{set, vw}] = {1'b0, taken};
            end
        end
        if (!ch && (hit || taken)) begin
            if (hit) begin
                tk_cnt[{set, hit1}] = nudge_ctr(hit0 ? c0 : c1, taken);
            end else begin
                // evict the way that predicts not taken, else follow replace bit
                vw = (c0[1] != c1[1]) ? c0[1] : !tk_repl[set];
                tk_tag[{set, vw}] = tag;
                tk_cnt[{set, vw}] = {1'b0, taken};
            end
        end
        ghist = {ghist[SET_BITS-1:0], taken};
        return v;
    endfunction

    // Offer one branch transaction; return at the edge that accepts it.
    task automatic send_branch(yags_pkg::action_t act, logic [31:0] addr, logic taken,
                               logic pinned, verdict_t want);
        if (idle_on && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {7'b0, 1'($urandom), 32'($urandom)};
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= {7'b0, taken, addr};
        s_tuser    <= act;
        row_pinned <= pinned;
        row_result <= want;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_pending) begin
                stall_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= !(idle_on && $urandom_range(99) < 6);
            end
        end
    end

    // Check results first, then record the expectation for a new transaction,
    // so a result can never match the branch accepted on the same edge.
    always @(posedge aclk) begin
        verdict_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[2:0];
                if (pending_results.size() == 0) begin
                    $error("unexpected result transaction, m_tdata=%h", m_tdata);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.prediction !== want.prediction) begin
                        $error("prediction: expected %b, got %b",
                               want.prediction, got.prediction);
                        mismatches++;
                    end
                    if (got.cache_hit !== want.cache_hit) begin
                        $error("cache_hit: expected %b, got %b",
                               want.cache_hit, got.cache_hit);
                        mismatches++;
                    end
                    if (got.choice_taken !== want.choice_taken) begin
                        $error("choice_says_taken: expected %b, got %b",
                               want.choice_taken, got.choice_taken);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want = predict_branch(yags_pkg::action_t'(s_tuser[0]), s_tdata[31:0],
                                      s_tdata[32]);
                if (row_pinned) want = row_result;
                pending_results.push_back(want);
            end
        end
    end

    // Abort when nothing moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[yags_branch_predictor] ERROR");
            $finish;
        end
    end

    initial begin
        logic [31:0]       pool_addr [0:POOL_SIZE-1];
        logic              pool_bias [0:POOL_SIZE-1];
        logic [31:0]       addr;
        logic              taken;
        yags_pkg::action_t act;
        int                pick, r;

        for (int i = 0; i < (1 << CHOICE_BITS); i++) choice_ctr[i] = '0;
        for (int i = 0; i < (2 << SET_BITS); i++) begin
            tk_tag[i] = '0;
            tk_cnt[i] = '0;
            nt_tag[i] = '0;
            nt_cnt[i] = '0;
        end
        for (int i = 0; i < (1 << SET_BITS); i++) begin
            tk_repl[i] = 1'b0;
            nt_repl[i] = 1'b0;
        end
        ghist = '0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_addr[i] = $urandom;
            pool_bias[i] = 1'($urandom);
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_branch(directed_rows[i].act, directed_rows[i].addr, directed_rows[i].taken,
                        directed_rows[i].pinned, directed_rows[i].want);

        // Mostly a small set of hot branches with a per-branch bias, so the
        // caches fill, hit and evict; the rest is wide random and extreme addresses.
        for (int n = 0; n < RANDOM_BRANCHES; n++) begin
            if (n == 200) stall_pending = 1'b1;
            idle_on = !(n >= 400 && n < 550);
            r    = $urandom_range(99);
            pick = $urandom_range(POOL_SIZE - 1);
            if (r < 65)
                addr = pool_addr[pick];
            else if (r < 85)
                addr = $urandom;
            else if (r < 90)
                addr = 32'h0000_0000;
            else if (r < 95)
                addr = 32'hFFFF_FFFF;
            else
                addr = 32'h1 << $urandom_range(31);
            act   = ($urandom_range(99) < 65) ? yags_pkg::ACT_UPDATE : yags_pkg::ACT_LOOKUP;
            taken = (r < 65 && $urandom_range(99) < 80) ? pool_bias[pick] : 1'($urandom);
            send_branch(act, addr, taken, 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        // let the checker record the last accepted transaction first
        @(posedge aclk);

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[yags_branch_predictor] OK");
        end else begin
            $display("[yags_branch_predictor] ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
src/yags_pkg.sv
src/yags_branch_predictor.sv
verif/yags_branch_predictor_tb.sv
